/* hdl/chc_pkg.sv */
// chc_pkg.sv - shared constants, control structs and the sine table generator
// for the chorus core. No dependencies; imported by every chc_* module and by
// chorus_effect_core.
package chc_pkg;

    typedef longint unsigned u64_t;

    // Default build of the core
    localparam int DEF_BUFFER_DEPTH    = 4096;
    localparam int DEF_SAMPLE_WIDTH    = 24;
    localparam int DEF_SINE_TABLE_BITS = 8;

    // Fixed field widths
    localparam int PHASE_W     = 24;
    localparam int DELAY_CFG_W = 20;
    localparam int STEP_CFG_W  = 24;
    localparam int MIX_W       = 16;
    localparam int SINE_W      = 17;
    localparam int FRAC_W      = 8;
    localparam int Q15_SHIFT   = 15;

    // Serial multiplier: widest multiplier operand is mod_depth
    localparam int MPLR_W    = 20;
    localparam int STEP_W    = 5;
    // sine * mod_depth plus rounding needs 38 signed bits
    localparam int MIN_ACC_W = 38;

    localparam logic [STEP_W-1:0] STEPS_DELAY  = 5'd20;
    localparam logic [STEP_W-1:0] STEPS_INTERP = 5'd8;
    localparam logic [STEP_W-1:0] STEPS_MIX    = 5'd16;

    localparam int ROUND_Q15 = 16384;
    localparam int ROUND_Q8  = 128;

    // Register port
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int BYTE_SEL_W = 2;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_PRE_DELAY  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MOD_DEPTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_WET_MIX    = 2'd3;

    localparam logic [MIX_W-1:0] MIX_FULL      = 16'h8000;
    localparam logic [MIX_W-1:0] WET_MIX_RESET = 16'h4000;

    // Sine generation: 2*pi in Q30 and the Taylor term divisors (2n)(2n+1)
    localparam u64_t TWO_PI_Q30 = 64'd6746518852;
    localparam u64_t TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                        64'd110, 64'd156, 64'd210};

    typedef struct packed {
        logic              start;
        logic              keep_acc;
        logic [STEP_W-1:0] steps;
    } smac_ctrl_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } dline_ctrl_t;

    // Quarter-wave sine entry q of a 2^bits table, Q15, evaluated at elaboration
    function automatic logic [15:0] quarter_sine(input int unsigned q,
                                                 input int unsigned bits);
        u64_t   x;
        u64_t   x2;
        u64_t   term;
        longint sum;
        longint r;
        x    = (u64_t'(q) * TWO_PI_Q30) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 0; n < 7; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n[0] == 1'b0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (sum + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        return 16'(r);
    endfunction

endpackage

/* hdl/chc_sine.sv */
// chc_sine.sv - LFO sine lookup: quarter-wave table folded to a full cycle.
// Depends on chc_pkg (quarter_sine, SINE_W).
module chc_sine #(
    parameter int TABLE_BITS = chc_pkg::DEF_SINE_TABLE_BITS
) (
    input  logic                               clk,
    input  logic                               load,
    input  logic [TABLE_BITS-1:0]              idx,
    output logic signed [chc_pkg::SINE_W-1:0]  sine
);
    import chc_pkg::*;

    localparam int QN = 2 ** (TABLE_BITS - 2);

    logic [15:0]                quarter [QN+1];
    logic [1:0]                 quad;
    logic [TABLE_BITS-3:0]      r;
    logic [TABLE_BITS-2:0]      addr;
    logic signed [SINE_W-1:0]   mag;
    logic signed [SINE_W-1:0]   sine_reg;

    for (genvar k = 0; k <= QN; k++)
    begin : g_quarter
        assign quarter[k] = quarter_sine(k, TABLE_BITS);
    end

    assign quad = idx[TABLE_BITS-1:TABLE_BITS-2];
    assign r    = idx[TABLE_BITS-3:0];

    // Odd quadrants run the table backwards, the lower half-cycle negates
    always_comb
    begin
        addr = quad[0] ? ((TABLE_BITS-1)'(QN) - {1'b0, r}) : {1'b0, r};
        mag  = signed'({1'b0, quarter[addr]});
    end

    always_ff @(posedge clk)
    begin
        if (load)
            sine_reg <= quad[1] ? -mag : mag;
    end

    assign sine = sine_reg;

endmodule

/* hdl/chc_smac.sv */
// chc_smac.sv - bit-serial multiply-accumulate: one multiplier bit per cycle.
// Depends on chc_pkg (smac_ctrl_t, MPLR_W, STEP_W).
module chc_smac #(
    parameter int ACC_W = chc_pkg::MIN_ACC_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  chc_pkg::smac_ctrl_t               ctrl,
    input  logic signed [ACC_W-1:0]           acc_init,
    input  logic signed [ACC_W-1:0]           mcand,
    input  logic [chc_pkg::MPLR_W-1:0]        mplr,
    output logic                              busy,
    output logic signed [ACC_W-1:0]           acc
);
    import chc_pkg::*;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] mcand_reg;
    logic [MPLR_W-1:0]       mplr_reg;
    logic [STEP_W-1:0]       cnt_reg;
    logic [STEP_W-1:0]       cnt_next;

    assign busy = (cnt_reg != '0);

    // Add the shifted multiplicand when the current multiplier bit is set
    always_comb
    begin
        acc_next = mplr_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
        cnt_next = cnt_reg;
        if (ctrl.start)
            cnt_next = ctrl.steps;
        else if (busy)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            if (!ctrl.keep_acc)
                acc_reg <= acc_init;
            mcand_reg <= mcand;
            mplr_reg  <= mplr;
        end
        else if (busy)
        begin
            acc_reg   <= acc_next;
            mcand_reg <= mcand_reg <<< 1;
            mplr_reg  <= mplr_reg >> 1;
        end
    end

    assign acc = acc_reg;

endmodule

/* hdl/chc_dline.sv */
// chc_dline.sv - circular delay store with write pointer and fill tracking.
// Depends on chc_pkg (dline_ctrl_t).
module chc_dline #(
    parameter int DEPTH = chc_pkg::DEF_BUFFER_DEPTH,
    parameter int WIDTH = chc_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  chc_pkg::dline_ctrl_t        ctrl,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    input  logic signed [WIDTH-1:0]     wr_data,
    output logic signed [WIDTH-1:0]     rd_data,
    output logic [$clog2(DEPTH)-1:0]    wr_pos
);
    import chc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic signed [WIDTH-1:0] store_reg [DEPTH];
    logic signed [WIDTH-1:0] rd_data_reg;
    logic                    rd_hit_reg;
    logic [AW-1:0]           wr_pos_reg;
    logic [AW-1:0]           wr_pos_next;
    logic                    wrapped_reg;
    logic                    at_end;

    assign at_end      = (wr_pos_reg == AW'(DEPTH - 1));
    assign wr_pos_next = at_end ? '0 : wr_pos_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
            store_reg[wr_pos_reg] <= wr_data;
        if (ctrl.rd_en)
            rd_data_reg <= store_reg[rd_addr];
    end

    // Until the pointer has wrapped once, only entries below it hold samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg  <= '0;
            wrapped_reg <= 1'b0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.rd_en)
                rd_hit_reg <= wrapped_reg || (rd_addr < wr_pos_reg);
            if (ctrl.wr_en)
            begin
                wr_pos_reg <= wr_pos_next;
                if (at_end)
                    wrapped_reg <= 1'b1;
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;
    assign wr_pos  = wr_pos_reg;

endmodule

/* hdl/chorus_effect_core.sv */
// chorus_effect_core.sv - top level of the LFO-modulated delay chorus.
// Depends on chc_pkg, chc_sine, chc_smac and chc_dline.
//
// Chorus core: each request on the sample_in channel carries one signed audio
// sample and yields exactly one signed, saturated sample on sample_out. A
// 24-bit phase accumulator steps by phase_step per sample and addresses a
// Q1.15 sine table; the delay, in samples with 8 fraction bits, is pre_delay
// plus sine times mod_depth, clamped to zero and to BUFFER_DEPTH-1 whole
// samples. The delay line is read with linear interpolation before the new
// sample is written, and the output blends dry and wet by wet_mix (Q1.15,
// values above 32768 act as fully wet). A new request is taken only while the
// sequencer is idle, after the previous sample has reached the output register:
// one shared bit-serial multiplier handles 20 steps for the delay modulation,
// 8 for interpolation and 16 each for the dry and wet products, plus two
// single-port reads of the delay store. A finished sample waits in the output
// register while the next request is taken; a second sample finished before
// that one is taken holds the core until the output register frees up. The
// delay store needs no clearing pass: entries not yet written since reset read
// as zero. Registers sit at byte addresses 0, 4, 8 and 12 (pre_delay,
// mod_depth, phase_step, wet_mix); write them only while the core is idle. Any
// register write restarts the LFO at phase zero.
module chorus_effect_core #(
    parameter int BUFFER_DEPTH    = chc_pkg::DEF_BUFFER_DEPTH,
    parameter int SAMPLE_WIDTH    = chc_pkg::DEF_SAMPLE_WIDTH,
    parameter int SINE_TABLE_BITS = chc_pkg::DEF_SINE_TABLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [chc_pkg::PADDR_W-1:0]         paddr,
    input  logic [chc_pkg::PDATA_W-1:0]         pwdata,
    output logic [chc_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                sample_in_valid,
    output logic                                sample_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
    output logic                                sample_out_valid,
    input  logic                                sample_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);
    import chc_pkg::*;

    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int DLY_W = AW + FRAC_W;
    localparam int ACC_W = (SAMPLE_WIDTH + 17 > MIN_ACC_W) ? SAMPLE_WIDTH + 17 : MIN_ACC_W;

    localparam logic signed [ACC_W-1:0] DMAX =
        ACC_W'(longint'(BUFFER_DEPTH - 1) * longint'(1 << FRAC_W));
    localparam logic signed [ACC_W-1:0] SMAX =
        ACC_W'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - longint'(1));
    localparam logic signed [ACC_W-1:0] SMIN =
        ACC_W'(-(longint'(1) <<< (SAMPLE_WIDTH - 1)));

    // Sequencer states
    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DELAY_GO   = 4'd1;
    localparam logic [3:0] S_DELAY_RUN  = 4'd2;
    localparam logic [3:0] S_ADDR       = 4'd3;
    localparam logic [3:0] S_READ_B     = 4'd4;
    localparam logic [3:0] S_INTERP_GO  = 4'd5;
    localparam logic [3:0] S_INTERP_RUN = 4'd6;
    localparam logic [3:0] S_DRY_RUN    = 4'd7;
    localparam logic [3:0] S_WET_RUN    = 4'd8;

    logic [3:0]                      state_reg;
    logic [3:0]                      state_next;

    // Configuration and LFO
    logic [DELAY_CFG_W-1:0]          pre_delay_reg;
    logic [DELAY_CFG_W-1:0]          mod_depth_reg;
    logic [STEP_CFG_W-1:0]           phase_step_reg;
    logic [MIX_W-1:0]                wet_mix_reg;
    logic [PHASE_W-1:0]              lfo_phase_reg;
    logic [REG_IDX_W-1:0]            reg_idx;
    logic                            cfg_write;

    // Per-sample working registers
    logic signed [SAMPLE_WIDTH-1:0]  x_reg;
    logic signed [SAMPLE_WIDTH-1:0]  s0_reg;
    logic signed [SAMPLE_WIDTH-1:0]  wet_reg;
    logic signed [SAMPLE_WIDTH-1:0]  sample_out_reg;
    logic [DLY_W-1:0]                delay_reg;
    logic [FRAC_W-1:0]               f_reg;
    logic [AW-1:0]                   idx1_reg;
    logic                            out_valid_reg;

    logic                            in_accept;
    logic                            out_free;
    logic                            out_load;

    logic signed [SINE_W-1:0]        sine;

    smac_ctrl_t                      mac_ctrl;
    logic signed [ACC_W-1:0]         mac_init;
    logic signed [ACC_W-1:0]         mac_mcand;
    logic [MPLR_W-1:0]               mac_mplr;
    logic signed [ACC_W-1:0]         mac_acc;
    logic                            mac_busy;

    dline_ctrl_t                     line_ctrl;
    logic [AW-1:0]                   rd_addr;
    logic [AW-1:0]                   wr_pos;
    logic signed [SAMPLE_WIDTH-1:0]  rd_data;

    logic signed [ACC_W-1:0]         delay_sum;
    logic [DLY_W-1:0]                delay_clamped;
    logic [AW-1:0]                   ip;
    logic [FRAC_W-1:0]               fr;
    logic [AW:0]                     rd_sum;
    logic [AW-1:0]                   idx0;
    logic [AW-1:0]                   idx1;
    logic [MIX_W-1:0]                mix;
    logic [MIX_W-1:0]                dry;
    logic signed [ACC_W-1:0]         mix_res;
    logic signed [SAMPLE_WIDTH-1:0]  mix_sat;

    // ---------------------------------------------------------------
    // Register port: word-addressed, always ready
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[PADDR_W-1:BYTE_SEL_W];

    always_comb
    begin
        unique case (reg_idx)
            REG_PRE_DELAY:  prdata = PDATA_W'(pre_delay_reg);
            REG_MOD_DEPTH:  prdata = PDATA_W'(mod_depth_reg);
            REG_PHASE_STEP: prdata = PDATA_W'(phase_step_reg);
            REG_WET_MIX:    prdata = PDATA_W'(wet_mix_reg);
        endcase
    end

    // Hold configuration; any write restarts the LFO, otherwise advance the
    // phase once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_delay_reg  <= '0;
            mod_depth_reg  <= '0;
            phase_step_reg <= '0;
            wet_mix_reg    <= WET_MIX_RESET;
            lfo_phase_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_PRE_DELAY:  pre_delay_reg  <= pwdata[DELAY_CFG_W-1:0];
                REG_MOD_DEPTH:  mod_depth_reg  <= pwdata[DELAY_CFG_W-1:0];
                REG_PHASE_STEP: phase_step_reg <= pwdata[STEP_CFG_W-1:0];
                REG_WET_MIX:    wet_mix_reg    <= pwdata[MIX_W-1:0];
            endcase
            lfo_phase_reg <= '0;
        end
        else if (in_accept)
        begin
            lfo_phase_reg <= lfo_phase_reg + phase_step_reg;
        end
    end

    // ---------------------------------------------------------------
    // Handshakes: the output register decouples the two channels
    // ---------------------------------------------------------------
    assign sample_in_ready  = (state_reg == S_IDLE);
    assign in_accept        = sample_in_valid && sample_in_ready;
    assign out_free         = !out_valid_reg || sample_out_ready;
    assign sample_out_valid = out_valid_reg;
    assign sample_out       = sample_out_reg;

    // ---------------------------------------------------------------
    // Sub-blocks
    // ---------------------------------------------------------------
    chc_sine #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .clk  (clk),
        .load (in_accept),
        .idx  (lfo_phase_reg[PHASE_W-1 -: SINE_TABLE_BITS]),
        .sine (sine)
    );

    chc_smac #(
        .ACC_W (ACC_W)
    ) u_smac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .acc_init (mac_init),
        .mcand    (mac_mcand),
        .mplr     (mac_mplr),
        .busy     (mac_busy),
        .acc      (mac_acc)
    );

    chc_dline #(
        .DEPTH (BUFFER_DEPTH),
        .WIDTH (SAMPLE_WIDTH)
    ) u_dline (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (line_ctrl),
        .rd_addr (rd_addr),
        .wr_data (x_reg),
        .rd_data (rd_data),
        .wr_pos  (wr_pos)
    );

    // ---------------------------------------------------------------
    // Datapath around the shared multiplier
    // ---------------------------------------------------------------
    always_comb
    begin
        // Delay = pre_delay + round(sine * depth / 2^15), kept inside the store
        delay_sum = ACC_W'(signed'({1'b0, pre_delay_reg})) + (mac_acc >>> Q15_SHIFT);
        priority if (delay_sum < 0)
            delay_clamped = '0;
        else if (delay_sum > DMAX)
            delay_clamped = DLY_W'(DMAX);
        else
            delay_clamped = DLY_W'(delay_sum);

        // Older tap sits one further back when the delay has a fraction
        ip     = delay_reg[DLY_W-1:FRAC_W];
        fr     = delay_reg[FRAC_W-1:0];
        rd_sum = {1'b0, wr_pos} + (AW+1)'(BUFFER_DEPTH) - {1'b0, ip} - (AW+1)'(|fr);
        idx0   = (rd_sum >= (AW+1)'(BUFFER_DEPTH)) ? AW'(rd_sum - (AW+1)'(BUFFER_DEPTH))
                                                   : AW'(rd_sum);
        idx1   = (idx0 == AW'(BUFFER_DEPTH - 1)) ? '0 : idx0 + 1'b1;

        // Mix weights; anything above unity counts as fully wet
        mix = (wet_mix_reg > MIX_FULL) ? MIX_FULL : wet_mix_reg;
        dry = MIX_FULL - mix;

        mix_res = mac_acc >>> Q15_SHIFT;
        priority if (mix_res > SMAX)
            mix_sat = SAMPLE_WIDTH'(SMAX);
        else if (mix_res < SMIN)
            mix_sat = SAMPLE_WIDTH'(SMIN);
        else
            mix_sat = SAMPLE_WIDTH'(mix_res);
    end

    assign rd_addr = (state_reg == S_ADDR) ? idx0 : idx1_reg;

    // ---------------------------------------------------------------
    // Sequencer: one sample at a time through the serial multiplier
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        mac_ctrl   = '0;
        mac_init   = ACC_W'(ROUND_Q15);
        mac_mcand  = '0;
        mac_mplr   = '0;
        line_ctrl  = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_DELAY_GO;
            end
            S_DELAY_GO:
            begin
                // sine * mod_depth, rounding bias preloaded
                mac_ctrl.start = 1'b1;
                mac_ctrl.steps = STEPS_DELAY;
                mac_mcand      = ACC_W'(sine);
                mac_mplr       = mod_depth_reg;
                state_next     = S_DELAY_RUN;
            end
            S_DELAY_RUN:
            begin
                if (!mac_busy)
                    state_next = S_ADDR;
            end
            S_ADDR:
            begin
                line_ctrl.rd_en = 1'b1;
                state_next      = S_READ_B;
            end
            S_READ_B:
            begin
                line_ctrl.rd_en = 1'b1;
                state_next      = S_INTERP_GO;
            end
            S_INTERP_GO:
            begin
                // s0*256 + 128 + f*(s1 - s0); both taps read, so store the input
                mac_ctrl.start  = 1'b1;
                mac_ctrl.steps  = STEPS_INTERP;
                mac_init        = (ACC_W'(s0_reg) <<< FRAC_W) + ACC_W'(ROUND_Q8);
                mac_mcand       = ACC_W'(rd_data) - ACC_W'(s0_reg);
                mac_mplr        = MPLR_W'(f_reg);
                line_ctrl.wr_en = 1'b1;
                state_next      = S_INTERP_RUN;
            end
            S_INTERP_RUN:
            begin
                if (!mac_busy)
                begin
                    mac_ctrl.start = 1'b1;
                    mac_ctrl.steps = STEPS_MIX;
                    mac_mcand      = ACC_W'(x_reg);
                    mac_mplr       = MPLR_W'(dry);
                    state_next     = S_DRY_RUN;
                end
            end
            S_DRY_RUN:
            begin
                if (!mac_busy)
                begin
                    // Accumulate the wet product on top of the dry one
                    mac_ctrl.start    = 1'b1;
                    mac_ctrl.keep_acc = 1'b1;
                    mac_ctrl.steps    = STEPS_MIX;
                    mac_mcand         = ACC_W'(wet_reg);
                    mac_mplr          = MPLR_W'(mix);
                    state_next        = S_WET_RUN;
                end
            end
            S_WET_RUN:
            begin
                if (!mac_busy && out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (sample_out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            x_reg <= sample_in;
        if (state_reg == S_DELAY_RUN && !mac_busy)
            delay_reg <= delay_clamped;
        if (state_reg == S_ADDR)
        begin
            f_reg    <= '0 - fr;
            idx1_reg <= idx1;
        end
        if (state_reg == S_READ_B)
            s0_reg <= rd_data;
        if (state_reg == S_INTERP_RUN && !mac_busy)
            wet_reg <= SAMPLE_WIDTH'(mac_acc >>> FRAC_W);
        if (out_load)
            sample_out_reg <= mix_sat;
    end

endmodule

/* tb/sv/chorus_effect_core_tb.sv */
`timescale 1ns / 100ps
// chorus_effect_core_tb.sv - self-checking bench for the chorus core: a built-in
// LFO/delay-line predictor, a request driver and a result monitor.
// Depends on chc_pkg and chorus_effect_core.
module chorus_effect_core_tb;

    localparam int     SW           = chc_pkg::DEF_SAMPLE_WIDTH;
    localparam int     DEPTH        = chc_pkg::DEF_BUFFER_DEPTH;
    localparam int     TBITS        = chc_pkg::DEF_SINE_TABLE_BITS;
    localparam int     TABLE_N      = 1 << TBITS;
    localparam int     QN           = TABLE_N / 4;
    localparam longint DLY_MAX      = longint'(DEPTH - 1) * 256;
    localparam longint SMAX         = (longint'(1) << (SW - 1)) - 1;
    localparam longint SMIN         = -SMAX - 1;
    localparam longint unsigned LFO_TWO_PI = 64'd6746518852;
    localparam int     LIMIT_CYCLES = 1000000;
    localparam int     HOLD_CYCLES  = 600;
    localparam int     SEG_ITEMS    = 225;

    typedef struct {
        logic signed [SW-1:0] smp;
        bit                   drain_first;
    } pending_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [chc_pkg::PADDR_W-1:0]   paddr = '0;
    logic [chc_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [chc_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    logic                          sample_in_valid = 1'b0;
    logic                          sample_in_ready;
    logic signed [SW-1:0]          sample_in = '0;
    logic                          sample_out_valid;
    logic                          sample_out_ready = 1'b0;
    logic signed [SW-1:0]          sample_out;

    // Predictor state: delay line, write pointer, LFO accumulator and registers
    longint                        sine_tab [TABLE_N];
    logic signed [SW-1:0]          echo_line [DEPTH];
    longint                        echo_wr;
    logic [chc_pkg::PHASE_W-1:0]   lfo_acc;
    logic [19:0]                   cfg_pre;
    logic [19:0]                   cfg_depth;
    logic [23:0]                   cfg_step;
    logic [15:0]                   cfg_mix;

    pending_t                      pend_q [$];
    logic [SW-1:0]                 chorus_due_q [$];
    logic [SW-1:0]                 due_sample;
    int                            fault_count = 0;
    int                            cycle_count = 0;
    int                            send_idle_pct = 0;
    int                            recv_stall_pct = 0;
    bit                            hold_req = 1'b0;
    bit                            hold_ack = 1'b0;
    int                            hold_left = 0;

    chorus_effect_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .sample_in_valid  (sample_in_valid),
        .sample_in_ready  (sample_in_ready),
        .sample_in        (sample_in),
        .sample_out_valid (sample_out_valid),
        .sample_out_ready (sample_out_ready),
        .sample_out       (sample_out)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // First-quadrant sine in Q15: truncated Taylor series on a Q30 angle
    function automatic longint quarter_wave(input longint unsigned q);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint          sum;
        longint          r;
        ang  = (q * LFO_TWO_PI) >> TBITS;
        ang2 = (ang * ang) >> 30;
        term = ang;
        sum  = longint'(ang);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (sum + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        return r;
    endfunction

    // One chorus sample: LFO, modulated delay, interpolated tap, dry/wet blend
    function automatic logic [SW-1:0] chorus_predict(input logic signed [SW-1:0] dry);
        longint x;
        longint sine;
        longint dly;
        longint whole;
        longint frac;
        longint carry;
        longint weight;
        longint rd0;
        longint rd1;
        longint s0;
        longint s1;
        longint wet;
        longint mix;
        longint acc;
        x    = longint'(dry);
        sine = sine_tab[lfo_acc[chc_pkg::PHASE_W-1 -: TBITS]];
        lfo_acc = lfo_acc + cfg_step;

        dly = longint'(cfg_pre) + ((sine * longint'(cfg_depth) + 16384) >>> 15);
        if (dly < 0)
            dly = 0;
        if (dly > DLY_MAX)
            dly = DLY_MAX;

        whole  = dly >>> 8;
        frac   = dly & 255;
        carry  = (frac != 0) ? 1 : 0;
        weight = (256 - frac) & 255;
        rd0    = (echo_wr + DEPTH - whole - carry) % DEPTH;
        rd1    = (rd0 + 1) % DEPTH;
        s0     = longint'(echo_line[rd0]);
        s1     = longint'(echo_line[rd1]);
        wet    = (s0 * 256 + weight * (s1 - s0) + 128) >>> 8;

        echo_line[echo_wr] = dry;
        echo_wr = (echo_wr + 1) % DEPTH;

        mix = (cfg_mix > 16'h8000) ? 32768 : longint'(cfg_mix);
        acc = ((32768 - mix) * x + mix * wet + 16384) >>> 15;
        if (acc > SMAX)
            acc = SMAX;
        if (acc < SMIN)
            acc = SMIN;
        return acc[SW-1:0];
    endfunction

    // Register write: setup cycle, then access cycle; commit when pready is seen
    task automatic reg_write(input logic [chc_pkg::REG_IDX_W-1:0] idx,
                             input logic [chc_pkg::PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {chc_pkg::BYTE_SEL_W{1'b0}}};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            chc_pkg::REG_PRE_DELAY:  cfg_pre   = value[19:0];
            chc_pkg::REG_MOD_DEPTH:  cfg_depth = value[19:0];
            chc_pkg::REG_PHASE_STEP: cfg_step  = value[23:0];
            chc_pkg::REG_WET_MIX:    cfg_mix   = value[15:0];
            default: ;
        endcase
        // any write restarts the LFO
        lfo_acc = '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input logic [31:0] pre, input logic [31:0] depth,
                                 input logic [31:0] step, input logic [31:0] mix);
        reg_write(chc_pkg::REG_PRE_DELAY, pre);
        reg_write(chc_pkg::REG_MOD_DEPTH, depth);
        reg_write(chc_pkg::REG_PHASE_STEP, step);
        reg_write(chc_pkg::REG_WET_MIX, mix);
    endtask

    // Random setting; upper bus bits carry junk that the core must discard
    task automatic pick_setting();
        logic [31:0] pre;
        logic [31:0] depth;
        logic [31:0] step;
        logic [31:0] mix;
        pre   = $urandom;
        depth = $urandom;
        step  = $urandom;
        mix   = $urandom;
        case ($urandom_range(3))
            0: pre[19:0] = 20'($urandom_range(0, 20'h1FFF));
            1: pre[19:0] = 20'($urandom_range(0, 20'h3FF));
            2: pre[19:0] = 20'hFFFFF;
            default: ;
        endcase
        case ($urandom_range(3))
            0: depth[19:0] = '0;
            1: depth[19:0] = 20'($urandom_range(0, 20'h1FFF));
            2: depth[19:0] = 20'hFFFFF;
            default: ;
        endcase
        case ($urandom_range(3))
            0: step[23:0] = 24'($urandom_range(0, 24'hFFFF));
            1: step[23:0] = 24'($urandom_range(0, 24'h3FFFF));
            2: step[23:0] = 24'hFFFFFF;
            default: ;
        endcase
        case ($urandom_range(4))
            0: mix[15:0] = 16'($urandom_range(0, 32768));
            1: mix[15:0] = 16'($urandom_range(0, 32768));
            2: mix[15:0] = chc_pkg::MIX_FULL;
            3: mix[15:0] = '0;
            default: ;
        endcase
        apply_setting(pre, depth, step, mix);
    endtask

    task automatic queue_sample(input logic signed [SW-1:0] smp, input bit drain_first);
        pending_t p;
        p.smp         = smp;
        p.drain_first = drain_first;
        pend_q.push_back(p);
    endtask

    task automatic queue_burst(input int n);
        logic signed [SW-1:0] smp;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(7))
                0: smp = SW'(SMAX);
                1: smp = SW'(SMIN);
                2: smp = SW'(int'($urandom_range(0, 511)) - 256);
                default: smp = SW'($urandom);
            endcase
            // halfway through, hold the sender until every result is home
            queue_sample(smp, i == n / 2);
        end
    endtask

    // Idle means: nothing pending, no request on the wire, no result owed
    task automatic wait_idle();
        while (pend_q.size() != 0 || sample_in_valid || chorus_due_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Request driver: hold the payload until it is taken, then offer the next one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_in_valid <= 1'b0;
        end
        else
        begin
            if (sample_in_valid && sample_in_ready)
                chorus_due_q.push_back(chorus_predict(sample_in));
            if (!sample_in_valid || sample_in_ready)
            begin
                if (pend_q.size() != 0
                    && (!pend_q[0].drain_first || chorus_due_q.size() == 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    sample_in_valid <= 1'b1;
                    sample_in       <= pend_q[0].smp;
                    void'(pend_q.pop_front());
                end
                else
                begin
                    sample_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started by toggling hold_req
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compare each accepted sample with the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_out_ready <= 1'b0;
        end
        else
        begin
            if (sample_out_valid && sample_out_ready)
            begin
                if (chorus_due_q.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected sample_out %0d", sample_out);
                end
                else
                begin
                    due_sample = chorus_due_q.pop_front();
                    if (sample_out !== due_sample)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("sample_out mismatch: expected %0d, got %0d",
                                     $signed(due_sample), sample_out);
                    end
                end
            end
            if (hold_left != 0)
                sample_out_ready <= 1'b0;
            else
                sample_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("chorus_effect_core verification failed");
            $finish;
        end
    end

    initial
    begin
        // Build the sine table by quarter-wave symmetry and clear the predictor
        for (int k = 0; k < TABLE_N; k++)
        begin
            if (k <= QN)
                sine_tab[k] = quarter_wave(k);
            else if (k <= 2 * QN)
                sine_tab[k] = quarter_wave(2 * QN - k);
            else if (k <= 3 * QN)
                sine_tab[k] = -quarter_wave(k - 2 * QN);
            else
                sine_tab[k] = -quarter_wave(TABLE_N - k);
        end
        for (int k = 0; k < DEPTH; k++)
            echo_line[k] = '0;
        echo_wr   = 0;
        lfo_acc   = '0;
        cfg_pre   = '0;
        cfg_depth = '0;
        cfg_step  = '0;
        cfg_mix   = chc_pkg::WET_MIX_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: zero delay taps the oldest slot, half wet
        queue_sample(SW'(SMAX), 1'b0);
        queue_sample(SW'(SMIN), 1'b0);
        queue_sample('0, 1'b0);
        queue_sample(-1, 1'b0);
        queue_sample(1, 1'b0);
        queue_sample(24'h555555, 1'b0);
        wait_idle();

        // Fixed 1.5-sample delay, fully wet: interpolate between full-scale swings
        apply_setting(32'h180, 32'h0, 32'h0, {16'h0, chc_pkg::MIX_FULL});
        queue_sample(SW'(SMAX), 1'b0);
        queue_sample(SW'(SMIN), 1'b0);
        queue_sample(SW'(SMAX), 1'b0);
        queue_sample(SW'(SMIN), 1'b0);
        queue_sample('0, 1'b0);
        queue_sample(24'h123456, 1'b0);
        wait_idle();

        // Deepest swing, quarter-cycle LFO: negative delay clamps; mix above full
        apply_setting(32'h100, 32'hFFFFF, 32'h400000, 32'hFFFF);
        queue_sample(SW'(SMAX), 1'b0);
        queue_sample(SW'(SMIN), 1'b0);
        queue_sample(24'h2AAAAA, 1'b0);
        queue_sample(-2, 1'b0);
        queue_sample(SW'(SMAX), 1'b0);
        queue_sample(24'h0F0F0F, 1'b0);
        queue_sample(SW'(SMIN), 1'b0);
        wait_idle();

        // Longest base delay saturates; fastest LFO step; fully dry
        apply_setting(32'hFFFFF, 32'h0, 32'hFFFFFF, 32'h0);
        queue_sample(SW'(SMAX), 1'b0);
        queue_sample(SW'(SMIN), 1'b0);
        queue_sample(24'h7FFF00, 1'b0);
        queue_sample(-1, 1'b0);
        queue_sample('0, 1'b0);
        queue_sample(1, 1'b0);
        wait_idle();

        // Random segments, cycling through the idling patterns
        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            pick_setting();
            queue_burst(SEG_ITEMS);
            // first segment: starve the output while requests keep coming
            if (seg == 0)
                hold_req <= ~hold_req;
            wait_idle();
        end

        // Drain: let any stray result show itself
        repeat (100) @(posedge clk);
        if (fault_count == 0 && chorus_due_q.size() == 0)
            $display("chorus_effect_core verification clean");
        else
            $display("chorus_effect_core verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/chc_pkg.sv
hdl/chc_sine.sv
hdl/chc_smac.sv
hdl/chc_dline.sv
hdl/chorus_effect_core.sv
tb/sv/chorus_effect_core_tb.sv
